[hdl/bla_pkg.sv]
`default_nettype none
package bla_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned MS_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PROD_W = 19;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERCENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PERIOD_MS = 3'd4;

  localparam logic [SAMPLE_W-1:0] EMPTY_CODE_RST = 12'd2060;
  localparam logic [SAMPLE_W-1:0] FULL_CODE_RST = 12'd2370;
  localparam logic [PCT_W-1:0] ALARM_PERCENT_RST = 7'd10;
  localparam logic [MS_W-1:0] BEEP_MS_RST = 16'd300;
  localparam logic [MS_W-1:0] ALARM_PERIOD_MS_RST = 16'd600;

  typedef struct packed {
    logic charging;
    logic sleep_enter;
    logic sleep_exit;
    logic alarm_fired;
    logic buzzer_on;
  } flags_t;

endpackage
`default_nettype wire

[hdl/bla_if.sv]
`default_nettype none
interface bla_in_if;
  logic                          valid;
  logic                          ready;
  logic [bla_pkg::SAMPLE_W-1:0]  battery_sample;
  logic                          low_power_switch;
  logic [bla_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, output battery_sample, output low_power_switch,
                  output now_ms, input ready);
  modport sink (input valid, input battery_sample, input low_power_switch,
                input now_ms, output ready);
endinterface

interface bla_out_if;
  logic                       valid;
  logic                       ready;
  logic [bla_pkg::PCT_W-1:0]  percent;
  logic                       charging;
  logic                       sleep_enter;
  logic                       sleep_exit;
  logic                       alarm_fired;
  logic                       buzzer_on;

  modport source (output valid, output percent, output charging, output sleep_enter,
                  output sleep_exit, output alarm_fired, output buzzer_on, input ready);
  modport sink (input valid, input percent, input charging, input sleep_enter,
                input sleep_exit, input alarm_fired, input buzzer_on, output ready);
endinterface
`default_nettype wire

[hdl/battery_level_monitor_alarm_unit.sv]
`default_nettype none
// Battery gauge with low battery alarm. Each input item carries one ADC sample, the
// low power switch and the millisecond time; each yields exactly one result item. The
// sample joins a WINDOW_DEPTH-entry window held in a single-port memory with a running
// sum; the mean of the samples held so far is mapped from empty_code..full_code to a
// percentage saturated to 0..100. A single bit-serial divider, one quotient bit per
// cycle, is used up to twice per item (sum by count, then scaled offset by span unless
// the span is zero, which gives 0 or 100 directly). Items are taken one at a time; the
// result waits in an output register, so the next item is accepted while it is still
// pending. Configuration is written through cfg_we, cfg_index and cfg_wdata and must
// only change while no item is in flight.
module battery_level_monitor_alarm_unit #(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bla_in_if.sink                              in_ch,
  bla_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [bla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bla_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = bla_pkg::SAMPLE_W + CNT_W;
  localparam int unsigned DIVD_W = (SUM_W > bla_pkg::PROD_W) ? SUM_W : bla_pkg::PROD_W;
  localparam int unsigned DIVR_W = (CNT_W > bla_pkg::SAMPLE_W) ? CNT_W : bla_pkg::SAMPLE_W;
  localparam logic [bla_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
    bla_pkg::SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_MEAN,
    S_MAP,
    S_PCT,
    S_DONE
  } state_t;

  state_t state_r;

  logic [bla_pkg::SAMPLE_W-1:0] empty_code_r;
  logic [bla_pkg::SAMPLE_W-1:0] full_code_r;
  logic [bla_pkg::PCT_W-1:0]    alarm_percent_r;
  logic [bla_pkg::MS_W-1:0]     beep_ms_r;
  logic [bla_pkg::MS_W-1:0]     alarm_period_ms_r;

  logic                         switch_r;
  logic [bla_pkg::TIME_W-1:0]   now_r;
  logic [bla_pkg::SAMPLE_W-1:0] mean_r;
  logic [bla_pkg::PCT_W-1:0]    pct_r;
  logic                         neg_r;
  logic                         charging_r;
  logic [bla_pkg::TIME_W-1:0]   next_alarm_r;
  logic [bla_pkg::TIME_W-1:0]   buzzer_deadline_r;

  logic                         out_valid_r;
  logic [bla_pkg::PCT_W-1:0]    out_pct_r;
  bla_pkg::flags_t              out_flags_r;
  bla_pkg::flags_t              flags_nxt;
  logic [bla_pkg::TIME_W-1:0]   buzzer_deadline_nxt;
  logic                         fire;

  logic                         in_accept;
  logic                         out_free;
  logic                         win_done;
  logic [SUM_W-1:0]             win_sum;
  logic [CNT_W-1:0]             win_count;

  logic                         div_start;
  logic [DIVD_W-1:0]            div_dividend;
  logic [DIVR_W-1:0]            div_divisor;
  logic                         div_done;
  logic [DIVD_W-1:0]            div_q;

  logic [bla_pkg::SAMPLE_W:0]   off;
  logic [bla_pkg::SAMPLE_W:0]   span;
  logic [bla_pkg::SAMPLE_W:0]   off_abs;
  logic [bla_pkg::SAMPLE_W:0]   span_abs;
  logic [bla_pkg::PROD_W-1:0]   prod;
  logic                         span_zero;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  bla_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .sample (in_ch.battery_sample & SAMPLE_MASK),
    .done   (win_done),
    .sum    (win_sum),
    .count  (win_count)
  );

  assign off = {1'b0, mean_r} - {1'b0, empty_code_r};
  assign span = {1'b0, full_code_r} - {1'b0, empty_code_r};
  assign off_abs = off[bla_pkg::SAMPLE_W] ? (~off + 1'b1) : off;
  assign span_abs = span[bla_pkg::SAMPLE_W] ? (~span + 1'b1) : span;
  assign span_zero = (span == '0);
  assign prod = {1'b0, off_abs[bla_pkg::SAMPLE_W-1:0], 6'b0}
              + {2'b0, off_abs[bla_pkg::SAMPLE_W-1:0], 5'b0}
              + {5'b0, off_abs[bla_pkg::SAMPLE_W-1:0], 2'b0};

  always_comb begin
    div_start = 1'b0;
    div_dividend = DIVD_W'(win_sum);
    div_divisor = DIVR_W'(win_count);
    case (state_r)
      S_WIN: begin
        div_start = win_done;
      end
      S_MAP: begin
        div_start = !span_zero;
        div_dividend = DIVD_W'(prod);
        div_divisor = DIVR_W'(span_abs[bla_pkg::SAMPLE_W-1:0]);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bla_div #(
    .DIVD_W (DIVD_W),
    .DIVR_W (DIVR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    flags_nxt.sleep_enter = switch_r && !charging_r;
    flags_nxt.sleep_exit = !switch_r && charging_r;
    flags_nxt.charging = switch_r;
    fire = (pct_r < alarm_percent_r) && (next_alarm_r < now_r) && !switch_r;
    flags_nxt.alarm_fired = fire;
    buzzer_deadline_nxt = fire ? now_r + bla_pkg::TIME_W'(beep_ms_r) : buzzer_deadline_r;
    flags_nxt.buzzer_on = buzzer_deadline_nxt > now_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      empty_code_r <= bla_pkg::EMPTY_CODE_RST;
      full_code_r <= bla_pkg::FULL_CODE_RST;
      alarm_percent_r <= bla_pkg::ALARM_PERCENT_RST;
      beep_ms_r <= bla_pkg::BEEP_MS_RST;
      alarm_period_ms_r <= bla_pkg::ALARM_PERIOD_MS_RST;
      charging_r <= 1'b0;
      next_alarm_r <= '0;
      buzzer_deadline_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bla_pkg::CFG_EMPTY_CODE: empty_code_r <= cfg_wdata[bla_pkg::SAMPLE_W-1:0];
          bla_pkg::CFG_FULL_CODE: full_code_r <= cfg_wdata[bla_pkg::SAMPLE_W-1:0];
          bla_pkg::CFG_ALARM_PERCENT: alarm_percent_r <= cfg_wdata[bla_pkg::PCT_W-1:0];
          bla_pkg::CFG_BEEP_MS: beep_ms_r <= cfg_wdata;
          bla_pkg::CFG_ALARM_PERIOD_MS: alarm_period_ms_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            switch_r <= in_ch.low_power_switch;
            now_r <= in_ch.now_ms;
            state_r <= S_WIN;
          end
        end
        S_WIN: begin
          if (win_done) begin
            state_r <= S_MEAN;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean_r <= div_q[bla_pkg::SAMPLE_W-1:0];
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          neg_r <= off[bla_pkg::SAMPLE_W] ^ span[bla_pkg::SAMPLE_W];
          if (span_zero) begin
            pct_r <= off[bla_pkg::SAMPLE_W] ? '0 : bla_pkg::PCT_FULL;
            state_r <= S_DONE;
          end else begin
            state_r <= S_PCT;
          end
        end
        S_PCT: begin
          if (div_done) begin
            if (neg_r) begin
              pct_r <= '0;
            end else if (div_q > DIVD_W'(bla_pkg::PCT_FULL)) begin
              pct_r <= bla_pkg::PCT_FULL;
            end else begin
              pct_r <= div_q[bla_pkg::PCT_W-1:0];
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            charging_r <= switch_r;
            buzzer_deadline_r <= buzzer_deadline_nxt;
            if (fire) begin
              next_alarm_r <= now_r + bla_pkg::TIME_W'(alarm_period_ms_r);
            end
            out_pct_r <= pct_r;
            out_flags_r <= flags_nxt;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.percent = out_pct_r;
  assign out_ch.charging = out_flags_r.charging;
  assign out_ch.sleep_enter = out_flags_r.sleep_enter;
  assign out_ch.sleep_exit = out_flags_r.sleep_exit;
  assign out_ch.alarm_fired = out_flags_r.alarm_fired;
  assign out_ch.buzzer_on = out_flags_r.buzzer_on;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pct_r <= bla_pkg::PCT_FULL)
    else $error("percent above full scale");
  a_fire_not_charging: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_flags_r.alarm_fired |-> !out_flags_r.charging)
    else $error("alarm fired while charging");
  a_sleep_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_flags_r.sleep_enter && out_flags_r.sleep_exit))
    else $error("sleep enter and exit together");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_WIN)
    else $error("accepted item did not start window update");
`endif

endmodule
`default_nettype wire

[hdl/bla_div.sv]
`default_nettype none
module bla_div #(
  parameter int unsigned DIVD_W = 19,
  parameter int unsigned DIVR_W = 12,
  localparam int unsigned CW = (DIVD_W > 1) ? $clog2(DIVD_W) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic [DIVD_W-1:0]      quotient
);

  logic [DIVD_W-1:0] q_r;
  logic [DIVR_W-1:0] divr_r;
  logic [DIVR_W-1:0] rem_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVR_W:0]   shifted;
  logic [DIVR_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, q_r[DIVD_W-1]};
  assign diff = shifted - {1'b0, divr_r};
  assign ge = !diff[DIVR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r <= dividend;
        divr_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
        q_r <= {q_r[DIVD_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

[hdl/bla_window.sv]
`default_nettype none
module bla_window #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned SUM_W = bla_pkg::SAMPLE_W + CNT_W
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [bla_pkg::SAMPLE_W-1:0] sample,
  output logic                              done,
  output logic [SUM_W-1:0]                  sum,
  output logic [CNT_W-1:0]                  count
);

  logic [bla_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [bla_pkg::SAMPLE_W-1:0] rd_data_r;
  logic [bla_pkg::SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]             slot_r;
  logic [IDX_W-1:0]             slot_nxt;
  logic [CNT_W-1:0]             count_r;
  logic [SUM_W-1:0]             sum_r;
  logic [SUM_W-1:0]             sum_nxt;
  logic                         busy_r;
  logic                         done_r;
  logic                         full;

  assign full = (count_r == CNT_W'(DEPTH));
  assign slot_nxt = (slot_r == IDX_W'(DEPTH - 1)) ? '0 : slot_r + 1'b1;
  assign sum_nxt = sum_r - (full ? SUM_W'(rd_data_r) : '0) + SUM_W'(sample_r);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[slot_r];
    if (busy_r) begin
      mem[slot_r] <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      slot_r <= '0;
      count_r <= '0;
      sum_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        sample_r <= sample;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
        sum_r <= sum_nxt;
        slot_r <= slot_nxt;
        if (!full) begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign sum = sum_r;
  assign count = count_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("window count beyond depth");
  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= IDX_W'(DEPTH - 1))
    else $error("write slot beyond depth");
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> sum_r <= SUM_W'(count_r) * SUM_W'((1 << bla_pkg::SAMPLE_W) - 1))
    else $error("window sum exceeds held samples");
`endif

endmodule
`default_nettype wire

[sim/battery_level_monitor_alarm_unit_test.sv]
`default_nettype none
module battery_level_monitor_alarm_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 180;

  typedef struct packed {
    logic [bla_pkg::SAMPLE_W-1:0] sample;
    logic                         sw;
    logic [bla_pkg::TIME_W-1:0]   now_ms;
  } reading_t;

  typedef struct packed {
    logic [bla_pkg::PCT_W-1:0] percent;
    bla_pkg::flags_t           flags;
  } gauge_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [bla_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bla_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bla_in_if in_ch();
  bla_out_if out_ch();

  battery_level_monitor_alarm_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // gauge settings as the block holds them
  logic [bla_pkg::SAMPLE_W-1:0] empty_code_q = bla_pkg::EMPTY_CODE_RST;
  logic [bla_pkg::SAMPLE_W-1:0] full_code_q = bla_pkg::FULL_CODE_RST;
  logic [bla_pkg::PCT_W-1:0] alarm_pct_q = bla_pkg::ALARM_PERCENT_RST;
  logic [bla_pkg::MS_W-1:0] beep_q = bla_pkg::BEEP_MS_RST;
  logic [bla_pkg::MS_W-1:0] period_q = bla_pkg::ALARM_PERIOD_MS_RST;

  // gauge state
  logic [bla_pkg::SAMPLE_W-1:0] win_mem [WINDOW];
  logic [5:0] slot_q = '0;
  logic [6:0] held_q = '0;
  logic [17:0] sum_q = '0;
  logic charging_q = 1'b0;
  logic [bla_pkg::TIME_W-1:0] next_alarm_q = '0;
  logic [bla_pkg::TIME_W-1:0] buzz_until_q = '0;

  reading_t reading_q[$];
  gauge_result_t gauge_q[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic gauge_result_t gauge_step(input logic [bla_pkg::SAMPLE_W-1:0] sample,
                                               input logic sw,
                                               input logic [bla_pkg::TIME_W-1:0] now);
    gauge_result_t res;
    logic [bla_pkg::SAMPLE_W-1:0] mean;
    logic [bla_pkg::PCT_W-1:0] pct;
    longint span;
    longint off;
    longint scaled;
    res = '0;
    if (held_q == 7'(WINDOW)) begin
      sum_q = sum_q - 18'(win_mem[slot_q]);
    end else begin
      held_q = held_q + 7'd1;
    end
    win_mem[slot_q] = sample;
    sum_q = sum_q + 18'(sample);
    slot_q = slot_q + 6'd1;
    mean = bla_pkg::SAMPLE_W'(sum_q / 18'(held_q));

    span = full_code_q;
    span = span - empty_code_q;
    off = mean;
    off = off - empty_code_q;
    if (span == 0) begin
      pct = (off >= 0) ? bla_pkg::PCT_FULL : '0;
    end else begin
      scaled = (off * 100) / span;
      if (scaled < 0) scaled = 0;
      if (scaled > 100) scaled = 100;
      pct = scaled[bla_pkg::PCT_W-1:0];
    end

    if (sw && !charging_q) begin
      charging_q = 1'b1;
      res.flags.sleep_enter = 1'b1;
    end else if (!sw && charging_q) begin
      charging_q = 1'b0;
      res.flags.sleep_exit = 1'b1;
    end

    if (pct < alarm_pct_q && next_alarm_q < now && !charging_q) begin
      buzz_until_q = now + bla_pkg::TIME_W'(beep_q);
      next_alarm_q = now + bla_pkg::TIME_W'(period_q);
      res.flags.alarm_fired = 1'b1;
    end

    res.percent = pct;
    res.flags.charging = charging_q;
    res.flags.buzzer_on = buzz_until_q > now;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  function automatic int clip_code(input int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  // driver: bursts of random length, random gaps, occasional drain pause
  always @(posedge clk) begin : drive
    int unsigned burst_left;
    int unsigned gap_left;
    bit drain_hold;
    bit launch;
    reading_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      drain_hold = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        gauge_q.push_back(gauge_step(in_ch.battery_sample, in_ch.low_power_switch,
                                     in_ch.now_ms));
      end
      if (!in_ch.valid || in_ch.ready) begin
        launch = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (drain_hold) begin
          if (gauge_q.size() == 0) drain_hold = 1'b0;
        end else if (reading_q.size() != 0) begin
          launch = 1'b1;
        end
        if (launch) begin
          nxt = reading_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.battery_sample <= nxt.sample;
          in_ch.low_power_switch <= nxt.sw;
          in_ch.now_ms <= nxt.now_ms;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(30, 120);
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 60)
                                                      : $urandom_range(0, 5);
            end
            drain_hold = ($urandom_range(0, 19) == 0);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result item, stall on a rotating pattern
  always @(posedge clk) begin : observe
    logic [15:0] stall_pat;
    int unsigned pat_age;
    gauge_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_pat = '1;
      pat_age = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (gauge_q.size() == 0) begin
          report_mismatch("result item with none pending", out_ch.percent, 0);
        end else begin
          want = gauge_q.pop_front();
          if (out_ch.percent !== want.percent)
            report_mismatch("percent", out_ch.percent, want.percent);
          if (out_ch.charging !== want.flags.charging)
            report_mismatch("charging", out_ch.charging, want.flags.charging);
          if (out_ch.sleep_enter !== want.flags.sleep_enter)
            report_mismatch("sleep_enter", out_ch.sleep_enter, want.flags.sleep_enter);
          if (out_ch.sleep_exit !== want.flags.sleep_exit)
            report_mismatch("sleep_exit", out_ch.sleep_exit, want.flags.sleep_exit);
          if (out_ch.alarm_fired !== want.flags.alarm_fired)
            report_mismatch("alarm_fired", out_ch.alarm_fired, want.flags.alarm_fired);
          if (out_ch.buzzer_on !== want.flags.buzzer_on)
            report_mismatch("buzzer_on", out_ch.buzzer_on, want.flags.buzzer_on);
        end
      end
      if (pat_age == 0) begin
        pat_age = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0: stall_pat = '1;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom | $urandom);
          default: stall_pat = 16'($urandom & $urandom);
        endcase
        if (stall_pat == '0) stall_pat = 16'h8000;
      end else begin
        pat_age--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      out_ch.ready <= stall_pat[0];
    end

    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_item(input int sample, input bit sw,
                            input logic [bla_pkg::TIME_W-1:0] now);
    reading_t r;
    r.sample = sample[bla_pkg::SAMPLE_W-1:0];
    r.sw = sw;
    r.now_ms = now;
    reading_q.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (reading_q.size() != 0 || in_ch.valid || gauge_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bla_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[bla_pkg::CFG_DATA_W-1:0];
    case (idx)
      bla_pkg::CFG_EMPTY_CODE: empty_code_q = val[bla_pkg::SAMPLE_W-1:0];
      bla_pkg::CFG_FULL_CODE: full_code_q = val[bla_pkg::SAMPLE_W-1:0];
      bla_pkg::CFG_ALARM_PERCENT: alarm_pct_q = val[bla_pkg::PCT_W-1:0];
      bla_pkg::CFG_BEEP_MS: beep_q = val[bla_pkg::MS_W-1:0];
      bla_pkg::CFG_ALARM_PERIOD_MS: period_q = val[bla_pkg::MS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_gauge_cfg(input int unsigned empty_c, input int unsigned full_c,
                                 input int unsigned alarm, input int unsigned beep,
                                 input int unsigned period);
    write_reg(bla_pkg::CFG_EMPTY_CODE, empty_c);
    write_reg(bla_pkg::CFG_FULL_CODE, full_c);
    write_reg(bla_pkg::CFG_ALARM_PERCENT, alarm);
    write_reg(bla_pkg::CFG_BEEP_MS, beep);
    write_reg(bla_pkg::CFG_ALARM_PERIOD_MS, period);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int level;
    int lo;
    int hi;
    int sample;
    int unsigned r;
    int unsigned e;
    int unsigned f;
    bit sw;
    logic [bla_pkg::TIME_W-1:0] clock_ms;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.battery_sample = '0;
    in_ch.low_power_switch = 1'b0;
    in_ch.now_ms = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, charge transitions, alarm repeat and time wrap at reset settings
    queue_item(4095, 0, 32'd0);
    queue_item(0, 0, 32'd1);
    queue_item(0, 0, 32'd150);
    queue_item(0, 1, 32'd700);
    queue_item(0, 1, 32'd800);
    queue_item(0, 0, 32'd900);
    queue_item(2370, 0, 32'd1000);
    queue_item(2060, 0, 32'd1100);
    queue_item(2215, 0, 32'd1200);
    queue_item(4095, 1, 32'd1300);
    queue_item(4095, 0, 32'd1400);
    queue_item(0, 0, 32'hFFFF_FF00);
    queue_item(0, 0, 32'hFFFF_FFFF);
    queue_item(0, 0, 32'd0);
    queue_item(0, 0, 32'd5);
    queue_item(4095, 0, 32'h8000_0000);
    queue_item(12'hAAA, 0, 32'h5555_5555);
    queue_item(12'h555, 1, 32'hAAAA_AAAA);
    queue_item(0, 0, 32'hAAAA_AAAB);
    queue_item(0, 0, 32'hFFFF_FFFE);
    wait_drained();

    sw = 1'b0;
    clock_ms = 32'd2000;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: write_gauge_cfg(0, 4095, 50, 0, 0);
        2: write_gauge_cfg(4095, 0, 127, 65535, 65535);
        3: write_gauge_cfg(2048, 2048, 100, 1000, 100);
        4: write_gauge_cfg(1000, 1001, 0, 50, 200);
        default: begin
          e = $urandom_range(0, 4095);
          if ($urandom_range(0, 3) != 0 && e < 4095) f = $urandom_range(e + 1, 4095);
          else f = $urandom_range(0, 4095);
          write_gauge_cfg(e, f, $urandom_range(0, 127),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000)
                                                      : $urandom_range(0, 65535),
                          ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2000)
                                                      : $urandom_range(0, 65535));
        end
      endcase
      lo = (empty_code_q < full_code_q) ? empty_code_q : full_code_q;
      hi = (empty_code_q < full_code_q) ? full_code_q : empty_code_q;
      level = clip_code(int'($urandom_range(0, hi - lo + 400)) + lo - 200);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 49) == 0)
          level = clip_code(int'($urandom_range(0, hi - lo + 400)) + lo - 200);
        else
          level = clip_code(level + int'($urandom_range(0, 20)) - 10);
        if ($urandom_range(0, 99) < 6) sample = $urandom_range(0, 4095);
        else sample = clip_code(level + int'($urandom_range(0, 40)) - 20);
        if ($urandom_range(0, 24) == 0) sw = ~sw;
        r = $urandom_range(0, 99);
        if (r < 80) clock_ms += $urandom_range(80, 120);
        else if (r < 90) clock_ms += $urandom_range(0, 3000);
        else if (r < 94) clock_ms = $urandom;
        else if (r < 97) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        else clock_ms += 32'd70000 + $urandom_range(0, 1000);
        queue_item(sample, sw, clock_ms);
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (gauge_q.size() != 0) report_mismatch("results never delivered", gauge_q.size(), 0);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
hdl/bla_pkg.sv
hdl/bla_if.sv
hdl/bla_div.sv
hdl/bla_window.sv
hdl/battery_level_monitor_alarm_unit.sv
sim/battery_level_monitor_alarm_unit_test.sv
